>>> hw/rtl/stk_pkg.sv
`timescale 1ns / 1ps
// types and constants shared by the scan result table and its checker
// no dependencies

package stk_pkg;

  localparam int NAME_W = 256;

  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_RECORD = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [63:0]        ssid_part0;
    logic [63:0]        ssid_part1;
    logic [63:0]        ssid_part2;
    logic [63:0]        ssid_part3;
    logic [5:0]         ssid_length;
    logic signed [7:0]  signal_dbm;
    logic               is_secure;
  } item_t;

  typedef struct packed {
    logic               entry_present;
    logic [63:0]        out_ssid_part0;
    logic [63:0]        out_ssid_part1;
    logic [63:0]        out_ssid_part2;
    logic [63:0]        out_ssid_part3;
    logic [5:0]         out_ssid_length;
    logic signed [7:0]  out_signal_dbm;
    logic               out_secure;
    logic               last;
  } result_t;

  // one slot of the name memory; strength lives in a memory of its own
  typedef struct packed {
    logic              secure;
    logic [5:0]        len;
    logic [NAME_W-1:0] name;
  } slot_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PASS,
    ST_FETCH,
    ST_LOAD,
    ST_EMPTY
  } state_t;

endpackage

>>> hw/rtl/scan_result_top_k_table.sv
`timescale 1ns / 1ps
// scan result table: keeps the strongest distinct names of one scan
// depends on stk_pkg
//
//  channel   dir  handshake                  payload
//  item      in   item_valid / item_stall    stk_pkg::item_t
//  result    out  result_valid / result_stall stk_pkg::result_t
//
// start items and ignored records leave the table idle. a record walks the used
// slots through the slot memories, one read a cycle. a finish item runs one
// selection pass over the slots per result. reset clears the fill count, the
// record count and the control; slot contents stay undefined until written. a
// stalled result holds the sequencer at that result.

module scan_result_top_k_table #(
  parameter int MAX_ENTRIES  = 16,
  parameter int RECORD_LIMIT = 255,
  parameter int NAME_BYTES   = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  stk_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output stk_pkg::result_t result
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  stk_pkg::state_t state, state_next;

  // slot memories
  stk_pkg::slot_t    name_mem [MAX_ENTRIES];
  logic signed [7:0] str_mem  [MAX_ENTRIES];
  stk_pkg::slot_t    name_rd;
  logic signed [7:0] str_rd;
  logic [IW-1:0]     rd_addr;
  logic              name_we, str_we;
  logic [IW-1:0]     wr_addr;
  stk_pkg::slot_t    name_wd;

  logic [CW-1:0]     used_slots;
  logic [7:0]        records_seen;

  // item being worked on
  logic [stk_pkg::NAME_W-1:0] cur_name;
  logic [5:0]                 cur_len;
  logic signed [7:0]          cur_str;
  logic                       cur_sec;

  // walk over the slots
  logic [CW-1:0]     iss;
  logic              chk_valid;
  logic [IW-1:0]     chk_idx;
  logic signed [7:0] weak_str;
  logic [IW-1:0]     weak_idx;
  logic signed [7:0] best_str;
  logic [IW-1:0]     best_idx;
  logic              have_best;
  logic [MAX_ENTRIES-1:0] emitted;
  logic [CW-1:0]     emit_cnt;

  logic              accept, rd_go, hit, walk_end, out_free, load, is_last;
  logic [5:0]        len_clamp;
  logic [stk_pkg::NAME_W-1:0] name_mask;

  assign accept   = item_valid && !item_stall;
  assign out_free = !result_valid || !result_stall;
  assign is_last  = (CW'(emit_cnt + 1'b1) == used_slots);

  always_comb begin
    len_clamp = (item.ssid_length > 6'(NAME_BYTES)) ? 6'(NAME_BYTES) : item.ssid_length;
    for (int b = 0; b < stk_pkg::NAME_W / 8; b++) begin
      name_mask[b*8 +: 8] = (6'(b) < len_clamp) ? 8'hff : 8'h00;
    end
  end

  always_comb begin
    state_next = state;
    item_stall = (state != stk_pkg::ST_IDLE);
    hit        = (state == stk_pkg::ST_SCAN) && chk_valid &&
                 (name_rd.len == cur_len) && (name_rd.name == cur_name);
    rd_go      = ((state == stk_pkg::ST_SCAN) || (state == stk_pkg::ST_PASS)) &&
                 (iss < used_slots) && !hit;
    walk_end   = !(iss < used_slots) && !chk_valid;
    rd_addr    = rd_go ? iss[IW-1:0] : best_idx;
    name_we    = 1'b0;
    str_we     = 1'b0;
    wr_addr    = used_slots[IW-1:0];
    name_wd    = '{secure: cur_sec, len: cur_len, name: cur_name};
    load       = 1'b0;
    case (state)
      stk_pkg::ST_IDLE: begin
        if (accept) begin
          case (item.kind)
            stk_pkg::KIND_RECORD: begin
              if (records_seen < 8'(RECORD_LIMIT) && item.ssid_length != 6'd0) begin
                state_next = stk_pkg::ST_SCAN;
              end
            end
            stk_pkg::KIND_FINISH: begin
              state_next = (used_slots == '0) ? stk_pkg::ST_EMPTY : stk_pkg::ST_PASS;
            end
            default: state_next = stk_pkg::ST_IDLE;
          endcase
        end
      end
      stk_pkg::ST_SCAN: begin
        if (hit) begin
          // known name: keep the stronger reading
          str_we     = (cur_str > str_rd);
          wr_addr    = chk_idx;
          state_next = stk_pkg::ST_IDLE;
        end else if (walk_end) begin
          if (used_slots < CW'(MAX_ENTRIES)) begin
            name_we = 1'b1;
            str_we  = 1'b1;
          end else if (cur_str > weak_str) begin
            name_we = 1'b1;
            str_we  = 1'b1;
            wr_addr = weak_idx;
          end
          state_next = stk_pkg::ST_IDLE;
        end
      end
      stk_pkg::ST_PASS: begin
        if (walk_end) state_next = stk_pkg::ST_FETCH;
      end
      stk_pkg::ST_FETCH: state_next = stk_pkg::ST_LOAD;
      stk_pkg::ST_LOAD: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = is_last ? stk_pkg::ST_IDLE : stk_pkg::ST_PASS;
        end
      end
      stk_pkg::ST_EMPTY: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = stk_pkg::ST_IDLE;
        end
      end
      default: state_next = stk_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= stk_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    name_rd <= name_mem[rd_addr];
    str_rd  <= str_mem[rd_addr];
    if (name_we) name_mem[wr_addr] <= name_wd;
    if (str_we) str_mem[wr_addr] <= cur_str;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_slots   <= '0;
      records_seen <= '0;
      chk_valid    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      chk_valid <= rd_go;
      if (accept && item.kind == stk_pkg::KIND_START) begin
        used_slots   <= '0;
        records_seen <= '0;
      end
      if (accept && item.kind == stk_pkg::KIND_RECORD && records_seen < 8'(RECORD_LIMIT)) begin
        records_seen <= records_seen + 8'd1;
      end
      if (state == stk_pkg::ST_SCAN && !hit && walk_end && used_slots < CW'(MAX_ENTRIES)) begin
        used_slots <= used_slots + CW'(1);
      end
      if (load) result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_name  <= {item.ssid_part3, item.ssid_part2, item.ssid_part1, item.ssid_part0}
                   & name_mask;
      cur_len   <= len_clamp;
      cur_str   <= item.signal_dbm;
      cur_sec   <= item.is_secure;
      iss       <= '0;
      have_best <= 1'b0;
      emitted   <= '0;
      emit_cnt  <= '0;
    end
    if (rd_go) begin
      iss     <= iss + CW'(1);
      chk_idx <= iss[IW-1:0];
    end
    // weakest slot, lowest index on a tie
    if (state == stk_pkg::ST_SCAN && chk_valid && !hit &&
        (chk_idx == '0 || str_rd < weak_str)) begin
      weak_str <= str_rd;
      weak_idx <= chk_idx;
    end
    // strongest slot not yet sent, lowest index on a tie
    if (state == stk_pkg::ST_PASS && chk_valid && !emitted[chk_idx] &&
        (!have_best || str_rd > best_str)) begin
      best_str  <= str_rd;
      best_idx  <= chk_idx;
      have_best <= 1'b1;
    end
    if (state == stk_pkg::ST_PASS && walk_end) emitted[best_idx] <= 1'b1;
    if (load) begin
      if (state == stk_pkg::ST_LOAD) begin
        result.entry_present   <= 1'b1;
        result.out_ssid_part0  <= name_rd.name[63:0];
        result.out_ssid_part1  <= name_rd.name[127:64];
        result.out_ssid_part2  <= name_rd.name[191:128];
        result.out_ssid_part3  <= name_rd.name[255:192];
        result.out_ssid_length <= name_rd.len;
        result.out_signal_dbm  <= str_rd;
        result.out_secure      <= name_rd.secure;
        result.last            <= is_last;
        emit_cnt               <= emit_cnt + CW'(1);
        iss                    <= '0;
        have_best              <= 1'b0;
      end else begin
        result <= '{last: 1'b1, default: '0};
      end
    end
  end

endmodule

>>> hw/rtl/stk_checker.sv
`timescale 1ns / 1ps
// port checker for the scan result table, bound to the top level
// depends on stk_pkg and scan_result_top_k_table

module stk_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_stall,
  input stk_pkg::item_t   item,
  input logic             result_valid,
  input logic             result_stall,
  input stk_pkg::result_t result
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(result))
    else $error("stalled result changed");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.entry_present |-> result.last && result.out_ssid_length == 6'd0)
    else $error("empty table result malformed");

  a_start_quiet: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.kind == stk_pkg::KIND_START |=> !item_stall)
    else $error("start item did not finish in one cycle");

endmodule

bind scan_result_top_k_table stk_checker u_stk_checker (.*);

>>> tb/tb_scan_result_top_k_table.sv
`timescale 1ns / 1ps
// testbench for the scan result table: directed and random scans, predicted by a
// behavioural table model in a scoreboard class; depends on stk_pkg and the rtl top

module tb_scan_result_top_k_table;

  localparam int SLOTS     = 16;
  localparam int REC_LIMIT = 255;
  localparam int MAX_CYC   = 1000000;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  class scan_table_sb;
    logic [255:0]       nm[SLOTS];
    logic [5:0]         nlen[SLOTS];
    logic signed [7:0]  str[SLOTS];
    logic               sec[SLOTS];
    int                 used;
    int                 seen;
    stk_pkg::result_t   pending[$];
    int                 errors;

    function void clear();
      used = 0;
      seen = 0;
    endfunction

    function void note_item(stk_pkg::item_t it);
      logic [255:0]     name;
      logic [255:0]     mask;
      int               len;
      int               w;
      int               ord[SLOTS];
      int               j;
      int               key;
      stk_pkg::result_t r;
      case (it.kind)
        stk_pkg::KIND_START: clear();
        stk_pkg::KIND_RECORD: begin
          if (seen >= REC_LIMIT) return;
          seen++;
          len = (it.ssid_length > 32) ? 32 : it.ssid_length;
          if (len == 0) return;
          mask = (len == 32) ? '1 : ((256'd1 << (len * 8)) - 1);
          name = {it.ssid_part3, it.ssid_part2, it.ssid_part1, it.ssid_part0} & mask;
          for (int i = 0; i < used; i++)
            if (nlen[i] == len && nm[i] == name) begin
              if (it.signal_dbm > str[i]) str[i] = it.signal_dbm;
              return;
            end
          if (used < SLOTS) begin
            w = used;
            used++;
          end else begin
            w = 0;
            for (int i = 1; i < SLOTS; i++) if (str[i] < str[w]) w = i;
            if (!(it.signal_dbm > str[w])) return;
          end
          nm[w] = name; nlen[w] = 6'(len); str[w] = it.signal_dbm; sec[w] = it.is_secure;
        end
        stk_pkg::KIND_FINISH: begin
          if (used == 0) begin
            r = '0;
            r.last = 1'b1;
            pending.push_back(r);
            return;
          end
          for (int i = 0; i < used; i++) begin
            key = i;
            j = i;
            while (j > 0 && str[ord[j-1]] < str[key]) begin
              ord[j] = ord[j-1];
              j--;
            end
            ord[j] = key;
          end
          for (int k = 0; k < used; k++) begin
            r.entry_present   = 1'b1;
            {r.out_ssid_part3, r.out_ssid_part2, r.out_ssid_part1, r.out_ssid_part0}
              = nm[ord[k]];
            r.out_ssid_length = nlen[ord[k]];
            r.out_signal_dbm  = str[ord[k]];
            r.out_secure      = sec[ord[k]];
            r.last            = (k == used - 1);
            pending.push_back(r);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(stk_pkg::result_t got);
      stk_pkg::result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("result mismatch: expected %h actual %h", want, got);
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             item_valid;
  logic             item_stall;
  stk_pkg::item_t   item;
  logic             result_valid;
  logic             result_stall;
  stk_pkg::result_t result;

  scan_table_sb sb;
  int           cycles;
  logic [63:0]  pool_words[8];
  logic [5:0]   pool_lens[8];

  scan_result_top_k_table i_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one item, held until accepted
  task automatic send(stk_pkg::item_t it);
    int g;
    g = gap_len();
    repeat (g) @(negedge clk);
    item       = it;
    item_valid = 1'b1;
    do @(posedge clk); while (item_stall);
    sb.note_item(it);
    @(negedge clk);
    item_valid = 1'b0;
  endtask

  function automatic stk_pkg::item_t make_rec(logic [255:0] name, logic [5:0] len,
                                              logic signed [7:0] dbm, logic s);
    stk_pkg::item_t it;
    it.kind = stk_pkg::KIND_RECORD;
    {it.ssid_part3, it.ssid_part2, it.ssid_part1, it.ssid_part0} = name;
    it.ssid_length = len;
    it.signal_dbm  = dbm;
    it.is_secure   = s;
    return it;
  endfunction

  function automatic stk_pkg::item_t ctrl(logic [1:0] k);
    stk_pkg::item_t it;
    it.kind        = k;
    it.ssid_part0  = {$urandom, $urandom};
    it.ssid_part1  = {$urandom, $urandom};
    it.ssid_part2  = {$urandom, $urandom};
    it.ssid_part3  = {$urandom, $urandom};
    it.ssid_length = 6'($urandom);
    it.signal_dbm  = 8'($urandom);
    it.is_secure   = 1'($urandom);
    return it;
  endfunction

  // names drawn mostly from a small pool so that duplicates and evictions happen
  function automatic stk_pkg::item_t rand_rec();
    int   p;
    logic [255:0] name;
    p = $urandom_range(0, 7);
    name = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom};
    if ($urandom_range(0, 3) != 0)
      return make_rec({4{pool_words[p]}} ^ {192'd0, 64'(p)}, pool_lens[p],
                      8'($urandom), 1'($urandom));
    return make_rec(name, 6'($urandom_range(0, 63)), 8'($urandom), 1'($urandom));
  endfunction

  // receiver side stalls
  always @(negedge clk) begin
    if (rst) result_stall <= 1'b0;
    else if ($urandom_range(0, 99) < 30) result_stall <= ($urandom_range(0, 9) < 8);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYC) begin
      $display("** scan_result_top_k_table: FAILED **");
      $finish;
    end
  end

  initial begin
    int n;
    sb = new();
    sb.clear();
    sb.errors = 0;
    cycles = 0;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    result_stall = 1'b0;
    for (int i = 0; i < 8; i++) begin
      pool_words[i] = {$urandom, $urandom};
      pool_lens[i]  = 6'($urandom_range(1, 40));
    end
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // directed: empty finish, extremes, duplicates, long names, ignored kind
    send(ctrl(stk_pkg::KIND_FINISH));
    send(ctrl(stk_pkg::KIND_START));
    send(make_rec('1, 6'd32, 8'sd127, 1'b1));
    send(make_rec('1, 6'd63, -8'sd128, 1'b0));
    send(make_rec('1, 6'd0, 8'sd5, 1'b1));
    send(make_rec(256'h41, 6'd1, -8'sd128, 1'b0));
    send(make_rec(256'hFF41, 6'd1, 8'sd10, 1'b1));
    send(make_rec(256'h41, 6'd1, -8'sd50, 1'b1));
    send(ctrl(KIND_UNUSED));
    send(ctrl(stk_pkg::KIND_FINISH));
    for (int i = 0; i < 16; i++)
      send(make_rec(256'(i + 2), 6'd1, 8'(i % 3), i[0]));
    send(ctrl(stk_pkg::KIND_FINISH));

    // random scans: mostly records, with starts, finishes and ignored kinds
    n = 0;
    while (n < 90) begin
      if (n % 40 == 0) send(ctrl(stk_pkg::KIND_START));
      n++;
      case ($urandom_range(0, 19))
        0:       send(ctrl(stk_pkg::KIND_START));
        1, 2:    send(ctrl(stk_pkg::KIND_FINISH));
        3:       send(ctrl(KIND_UNUSED));
        default: send(rand_rec());
      endcase
    end
    send(ctrl(stk_pkg::KIND_FINISH));

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (sb.errors == 0) $display("** scan_result_top_k_table: PASSED **");
    else $display("** scan_result_top_k_table: FAILED **");
    $finish;
  end
endmodule

>>> filelist.f
hw/rtl/stk_pkg.sv
hw/rtl/scan_result_top_k_table.sv
hw/rtl/stk_checker.sv
tb/tb_scan_result_top_k_table.sv
